// ===== src/crs_pkg.sv =====
// Package for the cipher rotor stage: letter types, opcodes, register indexes,
// shared structs and modulo-alphabet helpers. No dependencies.
package crs_pkg;

    localparam int LETTERS = 26;
    localparam int LW      = 5;
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    typedef logic [LW-1:0] t_letter;
    typedef logic [LETTERS-1:0][LW-1:0] t_letter_vec;

    typedef enum logic [2:0] {
        OP_STEP     = 3'd0,
        OP_FORWARD  = 3'd1,
        OP_BACKWARD = 3'd2,
        OP_SET_POS  = 3'd3,
        OP_TEST     = 3'd4
    } t_opcode;

    localparam logic [2:0] REG_WIRING_LOW  = 3'd0;
    localparam logic [2:0] REG_WIRING_MID  = 3'd1;
    localparam logic [2:0] REG_WIRING_HIGH = 3'd2;
    localparam logic [2:0] REG_RING        = 3'd3;
    localparam logic [2:0] REG_NOTCH       = 3'd4;

    typedef struct packed {
        t_letter_vec        wiring;
        t_letter            ring;
        logic [LETTERS-1:0] notch;
    } t_cfg;

    typedef struct packed {
        t_letter_vec fwd;
        t_letter_vec inv;
    } t_tables;

    typedef struct packed {
        logic    at_notch;
        t_letter position_now;
        logic    notch_hit;
        t_letter letter_out;
    } t_result;

    function automatic t_letter red5(input t_letter v);
        return (v >= LW'(LETTERS)) ? t_letter'(v - LW'(LETTERS)) : v;
    endfunction

    function automatic t_letter red6(input logic [LW:0] v);
        logic [LW:0] d;
        d = v - (LW+1)'(LETTERS);
        return (v >= (LW+1)'(LETTERS)) ? d[LW-1:0] : v[LW-1:0];
    endfunction

endpackage

// ===== src/crs_cfg_regs.sv =====
// APB configuration registers of the cipher rotor stage.
// Depends on crs_pkg for register indexes and the configuration struct.
module crs_cfg_regs
    import crs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [59:0]        r_wiring_low;
    logic [59:0]        r_wiring_mid;
    logic [9:0]         r_wiring_high;
    t_letter            r_ring;
    logic [LETTERS-1:0] r_notch;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [LETTERS*LW-1:0] wiring_flat;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiring_low  <= '0;
            r_wiring_mid  <= '0;
            r_wiring_high <= '0;
            r_ring        <= '0;
            r_notch       <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIRING_LOW:  r_wiring_low  <= pwdata[59:0];
                REG_WIRING_MID:  r_wiring_mid  <= pwdata[59:0];
                REG_WIRING_HIGH: r_wiring_high <= pwdata[9:0];
                REG_RING:        r_ring        <= pwdata[LW-1:0];
                REG_NOTCH:       r_notch       <= pwdata[LETTERS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIRING_LOW:  prdata = {4'b0, r_wiring_low};
            REG_WIRING_MID:  prdata = {4'b0, r_wiring_mid};
            REG_WIRING_HIGH: prdata = {54'b0, r_wiring_high};
            REG_RING:        prdata = {59'b0, r_ring};
            REG_NOTCH:       prdata = {38'b0, r_notch};
            default:         prdata = '0;
        endcase
    end

    assign wiring_flat   = {r_wiring_high, r_wiring_mid, r_wiring_low};
    assign o_cfg.wiring  = t_letter_vec'(wiring_flat);
    assign o_cfg.ring    = r_ring;
    assign o_cfg.notch   = r_notch;

endmodule

// ===== src/crs_wire_tables.sv =====
// Registered forward and inverse wiring tables, rebuilt from the wiring registers.
// Depends on crs_pkg; the inverse takes the highest matching letter, else zero.
module crs_wire_tables
    import crs_pkg::*;
(
    input  logic    i_clk,
    input  t_cfg    i_cfg,
    output t_tables o_tables
);

    t_letter_vec r_fwd;
    t_letter_vec r_inv;
    t_letter_vec n_fwd;
    t_letter_vec n_inv;

    function automatic t_letter highest_set(input logic [LETTERS-1:0] m);
        t_letter r;
        r = '0;
        for (int k = 0; k < LETTERS; k++) begin
            if (m[k]) r = LW'(k);
        end
        return r;
    endfunction

    always_comb begin
        logic [LETTERS-1:0] match;
        for (int k = 0; k < LETTERS; k++) begin
            n_fwd[k] = red5(i_cfg.wiring[k]);
        end
        for (int v = 0; v < LETTERS; v++) begin
            for (int k = 0; k < LETTERS; k++) begin
                match[k] = (n_fwd[k] == LW'(v));
            end
            n_inv[v] = highest_set(match);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= n_fwd;
        r_inv <= n_inv;
    end

    assign o_tables.fwd = r_fwd;
    assign o_tables.inv = r_inv;

endmodule

// ===== src/crs_map_logic.sv =====
// Combinational result logic of the cipher rotor stage for one item.
// Depends on crs_pkg for opcodes, structs and the modulo helpers.
module crs_map_logic
    import crs_pkg::*;
(
    input  logic [2:0] i_opcode,
    input  t_letter    i_letter,
    input  t_letter    i_position,
    input  t_cfg       i_cfg,
    input  t_tables    i_tables,
    output t_result    o_result,
    output t_letter    o_next_position
);

    t_letter ring_r;
    t_letter let_r;
    t_letter shift;
    t_letter ps;
    t_letter w;
    t_letter lout;
    t_letter next_pos;
    logic    hit;

    always_comb begin
        ring_r = red5(i_cfg.ring);
        let_r  = red5(i_letter);
        shift  = red6({1'b0, i_position} + (LW+1)'(LETTERS) - {1'b0, ring_r});
        ps     = red6({1'b0, let_r} + {1'b0, shift});
        w      = (i_opcode == OP_FORWARD) ? i_tables.fwd[ps] : i_tables.inv[ps];
        lout   = '0;
        hit    = 1'b0;
        next_pos = i_position;
        case (i_opcode)
            OP_STEP: begin
                hit      = i_cfg.notch[i_position];
                next_pos = red5(i_position + LW'(1));
            end
            OP_FORWARD, OP_BACKWARD: begin
                lout = red6({1'b0, w} + (LW+1)'(LETTERS) - {1'b0, shift});
            end
            OP_SET_POS: begin
                next_pos = let_r;
            end
            OP_TEST: begin
                hit = i_cfg.notch[let_r];
            end
            default: ;
        endcase
    end

    assign o_result.letter_out   = lout;
    assign o_result.notch_hit    = hit;
    assign o_result.position_now = next_pos;
    assign o_result.at_notch     = i_cfg.notch[next_pos];
    assign o_next_position       = next_pos;

endmodule

// ===== src/cipher_rotor_stage_unit.sv =====
// Top level of the cipher rotor stage: input register, result logic, result register.
// Depends on crs_pkg, crs_cfg_regs, crs_wire_tables and crs_map_logic.
//
// The slave stream carries one item per transfer: the opcode in s_tuser and the
// letter in s_tdata. Each item yields exactly one result item on the master
// stream. An item is registered on acceptance, worked on against the rotor
// position while it sits in the input register, and its result is then held
// in the output register. One item is taken every cycle while the receiver does
// not stall; the only loop is the position register, updated as each item passes.
// When the receiver stalls, the input register still takes one item while the
// output register holds; further input waits until the result is taken.
// Reset clears the position to letter A, all configuration registers to zero
// and empties both stages. Configuration is written over the APB port, pready
// always high; the wiring tables are registered from the configuration, so they
// follow a write ahead of any item accepted afterwards.
module cipher_rotor_stage_unit
    import crs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [4:0] letter_in, [7:5] zero
    input  logic [2:0]         s_tuser,   // [2:0] opcode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [4:0] letter_out, [5] notch_hit,
                                          // [10:6] position_now, [11] at_notch
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg       cfg;
    t_tables    tables;
    t_result    result;
    t_letter    next_position;
    logic       r_in_valid;
    logic [2:0] r_in_op;
    t_letter    r_in_letter;
    logic       r_out_valid;
    t_result    r_out;
    t_letter    r_position;
    logic       advance;
    logic       s_accept;

    crs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    crs_wire_tables u_tables (
        .i_clk    (i_clk),
        .i_cfg    (cfg),
        .o_tables (tables)
    );

    crs_map_logic u_map (
        .i_opcode        (r_in_op),
        .i_letter        (r_in_letter),
        .i_position      (r_position),
        .i_cfg           (cfg),
        .i_tables        (tables),
        .o_result        (result),
        .o_next_position (next_position)
    );

    assign advance  = r_in_valid & (~r_out_valid | m_tready);
    assign s_tready = ~r_in_valid | advance;
    assign s_accept = s_tvalid & s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_position  <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_position  <= next_position;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_op     <= s_tuser;
            r_in_letter <= s_tdata[LW-1:0];
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0, r_out.at_notch, r_out.position_now,
                       r_out.notch_hit, r_out.letter_out};

endmodule
